/* sv/imadec_pkg.sv */
// package for the ima adpcm wav block decoder: types, tables and the decode step
`default_nettype none

package imadec_pkg;

  // limits of the block format
  localparam int MAX_CHANNELS         = 8;
  localparam int MAX_FRAMES_PER_BLOCK = 8192;
  localparam int CH_W                 = $clog2(MAX_CHANNELS);
  localparam int POS_W                = $clog2(MAX_CHANNELS * 4);
  localparam int FPB_W                = 14;
  localparam int FRM_W                = 13;
  localparam int CFG_IDX_W            = 2;
  localparam int CFG_DATA_W           = 14;
  localparam int IDX_MAX              = 88;
  localparam logic [3:0] NIB_MASK     = 4'h0F;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT     = 2'd0,
    CFG_FRAMES_PER_BLOCK  = 2'd1,
    CFG_LAST_BLOCK_FRAMES = 2'd2
  } cfg_reg_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] sample;
    logic [CH_W-1:0]    channel;
    logic               last_of_item;
    logic               block_done;
  } res_t;

  // per-channel decoder state
  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } ima_state_t;

  // standard ima step size table
  localparam logic [14:0] STEP_TABLE [IDX_MAX+1] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
    15'd29794, 15'd32767
  };

  // one ima adpcm nibble decode: shift-add difference, saturate, index adjust
  function automatic ima_state_t ima_step(ima_state_t st, logic [3:0] nib_in);
    logic [3:0]         nib;
    logic [6:0]         ci;
    logic [14:0]        stp;
    logic [16:0]        diff;
    logic signed [17:0] acc;
    logic signed [7:0]  ni;
    ima_state_t         r;
    nib  = nib_in & NIB_MASK;
    ci   = (st.idx > 7'(IDX_MAX)) ? 7'(IDX_MAX) : st.idx;
    stp  = STEP_TABLE[ci];
    diff = {5'd0, stp[14:3]}
         + (nib[2] ? {2'd0, stp} : 17'd0)
         + (nib[1] ? {3'd0, stp[14:1]} : 17'd0)
         + (nib[0] ? {4'd0, stp[14:2]} : 17'd0);
    if (nib[3]) begin
      acc = {{2{st.pred[15]}}, st.pred} - $signed({1'b0, diff});
    end else begin
      acc = {{2{st.pred[15]}}, st.pred} + $signed({1'b0, diff});
    end
    if (acc > 18'sd32767) begin
      r.pred = 16'sh7FFF;
    end else if (acc < -18'sd32768) begin
      r.pred = 16'sh8000;
    end else begin
      r.pred = acc[15:0];
    end
    // index moves by -1 for small codes, by 2, 4, 6, 8 for large ones
    if (nib[2]) begin
      ni = $signed({1'b0, ci}) + $signed({4'd0, nib[1:0], 1'b0}) + 8'sd2;
    end else begin
      ni = $signed({1'b0, ci}) - 8'sd1;
    end
    if (ni < 8'sd0) begin
      r.idx = 7'd0;
    end else if (ni > 8'(IDX_MAX)) begin
      r.idx = 7'(IDX_MAX);
    end else begin
      r.idx = ni[6:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/ima_adpcm_wav_block_decoder.sv */
// top level of the ima adpcm wav block decoder
//
// Bytes of IMA ADPCM WAV blocks enter on the in_ channel (valid/ready), one per
// item, with in_block_start on the first byte of each block and in_final_block
// on that byte when the block is the stream's last. Decoded samples leave on the
// out_ channel (valid/ready), tagged with channel, last_of_item and block_done.
// The cfg_ channel writes channel_count (0), frames_per_block (1) and
// last_block_frames (2); it is always ready and should be written between
// blocks while nothing is in flight.
// Path: a byte lands in the input register at its accepting edge; from there
// its samples are written into a four-entry result queue, whose head is
// offered on out_.
// Throughput: one byte per cycle while the queue holds two samples or fewer. A
// data byte decodes two nibbles through two chained IMA steps combinationally,
// and the out_ channel drains one sample per cycle while out_ready is high, so
// data bytes are held back by the queue, header bytes go at one per cycle.
// Reset (rst_n low at a clock edge) clears the queue, closes any open block and
// zeroes the channel states. A stalled receiver fills the queue; the block then
// holds in_ready low and keeps the byte in its input register.
`default_nettype none

module ima_adpcm_wav_block_decoder (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input byte channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [7:0]                           in_data_byte,
  input  wire                                  in_block_start,
  input  wire                                  in_final_block,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [15:0]                   out_sample,
  output logic [imadec_pkg::CH_W-1:0]          out_channel,
  output logic                                 out_last_of_item,
  output logic                                 out_block_done,
  // configuration write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [imadec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [imadec_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import imadec_pkg::*;

  // configuration registers
  logic [3:0]       ch_cnt_r;
  logic [FPB_W-1:0] fpb_r;
  logic [FRM_W-1:0] lbf_r;

  // input register
  logic       inv_r;
  logic [7:0] byte_r;
  logic       bs_r;
  logic       fb_r;

  // decoder state
  logic signed [15:0] pred_r [MAX_CHANNELS];
  logic [6:0]         sidx_r [MAX_CHANNELS];
  logic [7:0]         hlow_r, hlow_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [FRM_W-1:0]   fl_r, fl_nxt;
  logic [3:0]         gfl_r, gfl_nxt;
  logic               hdr_r, hdr_nxt;

  // result queue
  res_t       fifo_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  // combinational decode
  logic             proc, pop;
  logic [3:0]       cc;
  logic [CH_W-1:0]  ccm1;
  logic [FPB_W-1:0] fpb_e, total;
  logic [FRM_W-1:0] total_m1;
  logic             hdr_e;
  logic [POS_W-1:0] pos_e, pos2;
  logic [FRM_W-1:0] fl_e;
  logic [3:0]       gfl_e, gfl2;
  logic [CH_W-1:0]  ch_sel;
  logic [1:0]       sub;
  logic [3:0]       j0, j1;
  logic             v0, v1, grp_end;
  ima_state_t       st_cur, st_a, st_b, st_new;
  logic             wr_pred, wr_idx;
  res_t             res_a, res_b;
  logic [1:0]       n_res;

  assign cfg_ready = 1'b1;
  assign proc      = inv_r && (cnt_r <= 3'd2);
  assign in_ready  = !inv_r || proc;
  assign pop       = out_valid && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r <= 4'd1;
      fpb_r    <= 14'd1017;
      lbf_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT:     ch_cnt_r <= cfg_data[3:0];
        CFG_FRAMES_PER_BLOCK:  fpb_r    <= cfg_data[FPB_W-1:0];
        CFG_LAST_BLOCK_FRAMES: lbf_r    <= cfg_data[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      bs_r   <= in_block_start;
      fb_r   <= in_final_block;
    end
  end

  // effective register values
  always_comb begin
    if (ch_cnt_r == 4'd0) begin
      cc = 4'd1;
    end else if (ch_cnt_r > 4'(MAX_CHANNELS)) begin
      cc = 4'(MAX_CHANNELS);
    end else begin
      cc = ch_cnt_r;
    end
    ccm1 = 3'(cc - 4'd1);
    if (fpb_r == '0) begin
      fpb_e = 14'd1;
    end else if (fpb_r > 14'(MAX_FRAMES_PER_BLOCK)) begin
      fpb_e = 14'(MAX_FRAMES_PER_BLOCK);
    end else begin
      fpb_e = fpb_r;
    end
    if (fb_r && lbf_r != '0 && {1'b0, lbf_r} < fpb_e) begin
      total = {1'b0, lbf_r};
    end else begin
      total = fpb_e;
    end
    total_m1 = 13'(total - 14'd1);
  end

  // byte decode: header parse or up to two nibble steps
  always_comb begin
    hdr_e = hdr_r;
    pos_e = pos_r;
    fl_e  = fl_r;
    gfl_e = gfl_r;
    if (bs_r) begin
      hdr_e = 1'b1;
      pos_e = '0;
      fl_e  = total_m1;
      gfl_e = '0;
    end
    hdr_nxt  = hdr_e;
    pos_nxt  = pos_e;
    fl_nxt   = fl_e;
    gfl_nxt  = gfl_e;
    hlow_nxt = hlow_r;
    wr_pred  = 1'b0;
    wr_idx   = 1'b0;
    n_res    = 2'd0;
    res_a    = '0;
    res_b    = '0;

    // data group wraps after all channels
    if (!hdr_e && {1'b0, pos_e} >= {cc, 2'b00}) begin
      pos2 = '0;
    end else begin
      pos2 = pos_e;
    end
    ch_sel = pos2[POS_W-1:2];
    sub    = pos2[1:0];
    if (pos2 == '0) begin
      gfl2 = (fl_e < 13'd8) ? fl_e[3:0] : 4'd8;
    end else begin
      gfl2 = gfl_e;
    end
    j0      = {1'b0, sub, 1'b0};
    j1      = {1'b0, sub, 1'b1};
    v0      = j0 < gfl2;
    v1      = j1 < gfl2;
    grp_end = (fl_e == {9'd0, gfl2}) && (ch_sel == ccm1);

    st_cur = '{pred: pred_r[ch_sel], idx: sidx_r[ch_sel]};
    st_a   = ima_step(st_cur, byte_r[3:0]);
    st_b   = ima_step(st_a, byte_r[7:4]);
    st_new = st_a;

    if (hdr_e) begin
      if ({1'b0, ch_sel} >= cc) begin
        // channel count shrank under an open header
        hdr_nxt = 1'b0;
        pos_nxt = '0;
      end else begin
        case (sub)
          2'd0: hlow_nxt = byte_r;
          2'd1: begin
            wr_pred     = 1'b1;
            st_new.pred = {byte_r, hlow_r};
            n_res       = 2'd1;
            res_a       = '{sample: {byte_r, hlow_r}, channel: ch_sel, last_of_item: 1'b1,
                            block_done: (fl_e == '0) && (ch_sel == ccm1)};
          end
          2'd2: begin
            wr_idx = 1'b1;
            if (byte_r[7]) begin
              st_new.idx = 7'd0;
            end else if (byte_r > 8'(IDX_MAX)) begin
              st_new.idx = 7'(IDX_MAX);
            end else begin
              st_new.idx = byte_r[6:0];
            end
          end
          default: ;
        endcase
        if (sub == 2'd3 && ch_sel == ccm1) begin
          hdr_nxt = 1'b0;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_e + 1'b1;
        end
      end
    end else if (fl_e != '0) begin
      gfl_nxt = gfl2;
      if (v0) begin
        wr_pred = 1'b1;
        wr_idx  = 1'b1;
        n_res   = 2'd1;
        res_a   = '{sample: st_a.pred, channel: ch_sel, last_of_item: !v1,
                    block_done: grp_end && (j0 == gfl2 - 4'd1)};
      end
      if (v1) begin
        st_new = st_b;
        n_res  = 2'd2;
        res_b  = '{sample: st_b.pred, channel: ch_sel, last_of_item: 1'b1,
                   block_done: grp_end && (j1 == gfl2 - 4'd1)};
      end
      if ({1'b0, pos2} == 6'({cc, 2'b00} - 6'd1)) begin
        fl_nxt  = fl_e - {9'd0, gfl2};
        pos_nxt = '0;
      end else begin
        pos_nxt = pos2 + 1'b1;
      end
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pred_r[i] <= '0;
        sidx_r[i] <= '0;
      end
      hlow_r <= '0;
      pos_r  <= '0;
      fl_r   <= '0;
      gfl_r  <= '0;
      hdr_r  <= 1'b0;
    end else if (proc) begin
      if (wr_pred) begin
        pred_r[ch_sel] <= st_new.pred;
      end
      if (wr_idx) begin
        sidx_r[ch_sel] <= st_new.idx;
      end
      hlow_r <= hlow_nxt;
      pos_r  <= pos_nxt;
      fl_r   <= fl_nxt;
      gfl_r  <= gfl_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (proc) begin
        wp_r <= wp_r + n_res;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + (proc ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (proc && n_res != 2'd0) begin
      fifo_r[wp_r] <= res_a;
    end
    if (proc && n_res == 2'd2) begin
      fifo_r[wp_r + 2'd1] <= res_b;
    end
  end

  // output side
  assign out_valid        = cnt_r != 3'd0;
  assign out_sample       = fifo_r[rp_r].sample;
  assign out_channel      = fifo_r[rp_r].channel;
  assign out_last_of_item = fifo_r[rp_r].last_of_item;
  assign out_block_done   = fifo_r[rp_r].block_done;

`ifndef SYNTH
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");

  // group size never above eight frames
  a_gfl_bound: assert property (@(posedge clk) disable iff (!rst_n) gfl_r <= 4'd8)
    else $error("group frame count out of range");

  // step index of the addressed channel stays within the table
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r[ch_sel] <= 7'(IDX_MAX))
    else $error("step index out of range");

  // a two-sample byte only enters when the queue has room for both
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    proc && n_res == 2'd2 |=> cnt_r <= 3'd4 && cnt_r >= 3'd1)
    else $error("result queue lost a sample");
`endif

endmodule

`default_nettype wire
